@@ rtl/hks_pkg.sv @@
package hks_pkg;

    localparam int KEY_W    = 64;
    localparam int HALF_W   = 32;
    localparam int OCC_W    = 11;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 16;
    localparam int PAD_W    = OUT_W - OCC_W - STATUS_W;

    // Fibonacci hashing multiplier (2^64 divided by the golden ratio).
    localparam logic [KEY_W-1:0]  HASH_MULT    = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [HALF_W-1:0] HASH_MULT_HI = HASH_MULT[KEY_W-1:HALF_W];
    localparam logic [HALF_W-1:0] HASH_MULT_LO = HASH_MULT[HALF_W-1:0];

    localparam logic [OCC_W-1:0] LOAD_LIMIT_RESET = 11'd768;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND = 3'd0,
        ST_FOUND     = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_REFUSED   = 3'd3,
        ST_SENTINEL  = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        MODE_INSERT = 1'b0,
        MODE_QUERY  = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_LO_LO,
        MUL_HI_LO,
        MUL_LO_HI,
        MUL_DRAIN
    } t_mul_step;

endpackage

@@ rtl/hks_mul.sv @@
module hks_mul (
    input  logic                                  i_clk,
    input  logic [hks_pkg::HALF_W-1:0]            i_a,
    input  logic [hks_pkg::HALF_W-1:0]            i_b,
    output logic [2*hks_pkg::HALF_W-1:0]          o_p
);

    logic [2*hks_pkg::HALF_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {{hks_pkg::HALF_W{1'b0}}, i_a} * {{hks_pkg::HALF_W{1'b0}}, i_b};
    end

    assign o_p = r_p;

endmodule

@@ rtl/hks_slots.sv @@
module hks_slots #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [ADDR_W-1:0]           i_wr_addr,
    input  logic [hks_pkg::KEY_W-1:0]   i_wr_data,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    output logic [hks_pkg::KEY_W-1:0]   o_rd_data
);

    logic [hks_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [hks_pkg::KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/hash_key_set.sv @@
// Open-addressed set of nonzero 64-bit keys in a table of TABLE_SLOTS slots (a power of
// two). After reset the block sweeps the table to zero, one slot a cycle, and accepts no
// transfer until the sweep ends; configuration writes are taken throughout. Each item is
// then accepted, hashed to its home slot (the 64-bit Fibonacci product is built from three
// 32x32 partial products on one shared multiplier), probed slot by slot (a registered
// table read, then a compare, per slot) and handed to the output register; a zero
// key or an insert refused at the load limit goes straight to the output register. One item
// is in flight at a time; the next may be accepted while the previous result still waits
// on the output.
module hash_key_set #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hks_pkg::OCC_W-1:0]   i_cfg_wdata,   // load_limit
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [hks_pkg::KEY_W-1:0]   s_tdata,       // [63:0] key
    input  logic                        s_tuser,       // [0] mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hks_pkg::OUT_W-1:0]   m_tdata        // [2:0] status, [13:3] occupancy
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W = CNT_W + hks_pkg::OCC_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    hks_pkg::t_state    r_state, n_state;
    hks_pkg::t_mul_step r_step;
    hks_pkg::t_status   r_status;
    hks_pkg::t_status   r_out_status;

    logic [hks_pkg::OCC_W-1:0]  r_load_limit;
    logic [CNT_W-1:0]           r_count;
    logic [IDX_W-1:0]           r_addr;
    logic [IDX_W-1:0]           r_probes;
    logic [hks_pkg::KEY_W-1:0]  r_key;
    logic                       r_mode;
    logic [hks_pkg::HALF_W-1:0] r_acc;
    logic                       r_out_valid;
    logic [hks_pkg::OCC_W-1:0]  r_out_occ;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_early;
    logic                        w_empty;
    logic                        w_hit;
    logic                        w_last;
    logic                        w_load_out;
    logic                        w_wr_en;
    logic [IDX_W-1:0]            w_wr_addr;
    logic [hks_pkg::KEY_W-1:0]   w_wr_data;
    logic [hks_pkg::KEY_W-1:0]   w_rd_data;
    logic [hks_pkg::HALF_W-1:0]  w_mul_a;
    logic [hks_pkg::HALF_W-1:0]  w_mul_b;
    logic [2*hks_pkg::HALF_W-1:0] w_mul_p;
    logic [hks_pkg::HALF_W-1:0]  w_acc_sum;
    logic [CMP_W-1:0]            w_count_ext;
    logic [CMP_W-1:0]            w_limit_ext;

    assign w_accept    = s_tvalid && s_tready;
    assign w_count_ext = CMP_W'(r_count);
    assign w_limit_ext = CMP_W'(r_load_limit);
    assign w_full      = w_count_ext >= w_limit_ext;
    assign w_early     = (s_tdata == '0)
                         || ((s_tuser == hks_pkg::MODE_INSERT) && w_full);

    assign w_empty = (w_rd_data == '0);
    assign w_hit   = (w_rd_data == r_key);
    assign w_last  = (r_probes == LAST_IDX);

    // Bits 63:32 of the product modulo 2^64: high half of lo*lo plus the low halves of
    // both cross terms. Products arrive in the cycle after their operands.
    assign w_acc_sum = (r_step == hks_pkg::MUL_HI_LO) ? w_mul_p[2*hks_pkg::HALF_W-1:hks_pkg::HALF_W]
                                                      : r_acc + w_mul_p[hks_pkg::HALF_W-1:0];

    hks_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    hks_slots #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (IDX_W)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hks_pkg::S_CLEAR: begin
                if (r_addr == LAST_IDX) n_state = hks_pkg::S_IDLE;
            end
            hks_pkg::S_IDLE: begin
                if (w_accept) n_state = w_early ? hks_pkg::S_DONE : hks_pkg::S_MUL;
            end
            hks_pkg::S_MUL: begin
                if (r_step == hks_pkg::MUL_DRAIN) n_state = hks_pkg::S_READ;
            end
            hks_pkg::S_READ: begin
                n_state = hks_pkg::S_CMP;
            end
            hks_pkg::S_CMP: begin
                n_state = (w_empty || w_hit || w_last) ? hks_pkg::S_DONE : hks_pkg::S_READ;
            end
            hks_pkg::S_DONE: begin
                if (w_load_out) n_state = hks_pkg::S_IDLE;
            end
            default: n_state = hks_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        s_tready   = (r_state == hks_pkg::S_IDLE);
        w_load_out = (r_state == hks_pkg::S_DONE) && (!r_out_valid || m_tready);
        w_wr_en    = 1'b0;
        w_wr_addr  = r_addr;
        w_wr_data  = r_key;
        w_mul_a    = '0;
        w_mul_b    = '0;
        unique case (r_state)
            hks_pkg::S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_data = '0;
            end
            hks_pkg::S_MUL: begin
                unique case (r_step)
                    hks_pkg::MUL_LO_LO: begin
                        w_mul_a = r_key[hks_pkg::HALF_W-1:0];
                        w_mul_b = hks_pkg::HASH_MULT_LO;
                    end
                    hks_pkg::MUL_HI_LO: begin
                        w_mul_a = r_key[hks_pkg::KEY_W-1:hks_pkg::HALF_W];
                        w_mul_b = hks_pkg::HASH_MULT_LO;
                    end
                    hks_pkg::MUL_LO_HI: begin
                        w_mul_a = r_key[hks_pkg::HALF_W-1:0];
                        w_mul_b = hks_pkg::HASH_MULT_HI;
                    end
                    default: begin
                        w_mul_a = '0;
                        w_mul_b = '0;
                    end
                endcase
            end
            hks_pkg::S_CMP: begin
                w_wr_en = w_empty && (r_mode == hks_pkg::MODE_INSERT);
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hks_pkg::S_CLEAR;
            r_step       <= hks_pkg::MUL_LO_LO;
            r_addr       <= '0;
            r_count      <= '0;
            r_load_limit <= hks_pkg::LOAD_LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_load_limit <= i_cfg_wdata;

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                hks_pkg::S_CLEAR: begin
                    r_addr <= r_addr + IDX_W'(1);
                end
                hks_pkg::S_IDLE: begin
                    r_step <= hks_pkg::MUL_LO_LO;
                end
                hks_pkg::S_MUL: begin
                    r_step <= hks_pkg::t_mul_step'(r_step + 2'd1);
                    if (r_step == hks_pkg::MUL_DRAIN) begin
                        r_addr <= w_acc_sum[IDX_W-1:0];
                    end
                end
                hks_pkg::S_CMP: begin
                    if (w_wr_en) begin
                        r_count <= r_count + CNT_W'(1);
                    end else if (!w_hit && !w_empty) begin
                        r_addr <= r_addr + IDX_W'(1);
                    end
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hks_pkg::S_IDLE: begin
                r_key    <= s_tdata;
                r_mode   <= s_tuser;
                r_probes <= '0;
                if (s_tdata == '0) begin
                    r_status <= hks_pkg::ST_SENTINEL;
                end else begin
                    r_status <= hks_pkg::ST_REFUSED;
                end
            end
            hks_pkg::S_MUL: begin
                if (r_step != hks_pkg::MUL_LO_LO) r_acc <= w_acc_sum;
            end
            hks_pkg::S_CMP: begin
                r_probes <= r_probes + IDX_W'(1);
                priority if (w_empty) begin
                    r_status <= (r_mode == hks_pkg::MODE_INSERT) ? hks_pkg::ST_INSERTED
                                                                 : hks_pkg::ST_NOT_FOUND;
                end else if (w_hit) begin
                    r_status <= hks_pkg::ST_FOUND;
                end else begin
                    // Every slot probed without a match or a gap.
                    r_status <= (r_mode == hks_pkg::MODE_INSERT) ? hks_pkg::ST_REFUSED
                                                                 : hks_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                r_status <= r_status;
            end
        endcase

        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_occ    <= w_count_ext[hks_pkg::OCC_W-1:0];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{hks_pkg::PAD_W{1'b0}}, r_out_occ, r_out_status};

endmodule

@@ rtl/hks_check.sv @@
module hks_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [hks_pkg::OUT_W-1:0]   m_tdata
);

    // A result held back by the consumer must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer accepted while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[2:0] == hks_pkg::ST_NOT_FOUND
                      || m_tdata[2:0] == hks_pkg::ST_FOUND
                      || m_tdata[2:0] == hks_pkg::ST_INSERTED
                      || m_tdata[2:0] == hks_pkg::ST_REFUSED
                      || m_tdata[2:0] == hks_pkg::ST_SENTINEL))
        else $error("undefined status");

    a_insert_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[2:0] == hks_pkg::ST_INSERTED) |-> (m_tdata[13:3] != 11'd0))
        else $error("insert reported with empty table");

endmodule

bind hash_key_set hks_check u_hks_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
